[design/sndag_pkg.sv]
`timescale 1ns / 1ps

package sndag_pkg;

    // Default dimension capacity
    localparam int DEF_MAX_DIMS = 8;

    // Field widths
    localparam int ADDR_W     = 64;
    localparam int EXT_W      = 32;
    localparam int DIM_W      = 3;
    localparam int OP_W       = 2;
    localparam int DIMS_CFG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS_IN_USE = 2'd0,
        CFG_REVERSE     = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_WRITE,
        ST_WALK,
        ST_EMIT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic load_mul;
        logic load_write;
        logic start;
        logic walk;
        logic emit;
        logic emit_done;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic advance;
    } t_dp_status;

endpackage

[design/sndag_if.sv]
`timescale 1ns / 1ps

interface sndag_in_if import sndag_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [DIM_W-1:0]         dim_index;
    logic [EXT_W-1:0]         iteration_extent;
    logic [EXT_W-1:0]         source_extent;
    logic signed [ADDR_W-1:0] stride;
    logic [ADDR_W-1:0]        start_address;

    modport source (
        output valid, op, dim_index, iteration_extent, source_extent, stride,
               start_address,
        input  ready
    );
    modport sink (
        input  valid, op, dim_index, iteration_extent, source_extent, stride,
               start_address,
        output ready
    );
endinterface

interface sndag_out_if import sndag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic              done_res;

    modport source (output valid, address, done_res, input ready);
    modport sink   (input valid, address, done_res, output ready);
endinterface

interface sndag_cfg_if import sndag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/sndag_dp.sv]
`timescale 1ns / 1ps

module sndag_dp import sndag_pkg::*; #(
    parameter int  MAX_DIMS = DEF_MAX_DIMS,
    localparam int IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [IDX_W-1:0]         i_walk_dim,
    output t_dp_status               o_status,
    input  logic [DIM_W-1:0]         i_dim_index,
    input  logic [EXT_W-1:0]         i_iteration_extent,
    input  logic [EXT_W-1:0]         i_source_extent,
    input  logic signed [ADDR_W-1:0] i_stride,
    input  logic [ADDR_W-1:0]        i_start_address,
    output logic [ADDR_W-1:0]        o_address,
    output logic                     o_done_res
);

    // Per-dimension state
    logic [EXT_W-1:0]  r_coord  [MAX_DIMS];
    logic [EXT_W-1:0]  r_iter   [MAX_DIMS];
    logic              r_reduce [MAX_DIMS];  // iteration extent == source extent
    logic [ADDR_W-1:0] r_stride [MAX_DIMS];
    logic [ADDR_W-1:0] r_wrap   [MAX_DIMS];  // stride * (source_extent - 1)
    logic [ADDR_W-1:0] r_addr;

    // Load staging
    logic [DIM_W-1:0]  r_ld_dim;
    logic [EXT_W-1:0]  r_ld_iter;
    logic [EXT_W-1:0]  r_ld_src;
    logic [ADDR_W-1:0] r_ld_stride;
    logic [ADDR_W-1:0] r_prod_lo;
    logic [EXT_W-1:0]  r_prod_hi;
    logic              r_src_zero;

    logic [ADDR_W-1:0] r_out_address;
    logic              r_out_done;

    logic [EXT_W-1:0]  factor;
    logic [ADDR_W-1:0] prod_lo;
    logic [EXT_W-1:0]  prod_hi;
    logic [ADDR_W-1:0] wrap;
    logic [EXT_W:0]    next_coord;
    logic              adv;
    logic [ADDR_W-1:0] n_addr;

    // 64x32 product split into two 32x32 halves, low 64 bits kept
    assign factor  = r_ld_src - EXT_W'(1);
    assign prod_lo = ADDR_W'(r_ld_stride[EXT_W-1:0]) * ADDR_W'(factor);
    assign prod_hi = EXT_W'(r_ld_stride[ADDR_W-1:EXT_W] * factor);
    // zero source extent: (0 - 1) mod 2^64 turns the wrap into -stride
    assign wrap    = r_src_zero ? (ADDR_W'(0) - r_ld_stride)
                                : (r_prod_lo + {r_prod_hi, EXT_W'(0)});

    assign next_coord = {1'b0, r_coord[i_walk_dim]} + (EXT_W+1)'(1);
    assign adv        = next_coord < {1'b0, r_iter[i_walk_dim]};
    assign o_status.advance = adv;

    always_comb begin
        n_addr = r_addr;
        if (i_cmd.start) begin
            n_addr = i_start_address;
        end else if (i_cmd.walk) begin
            if (!adv) begin
                n_addr = r_addr - r_wrap[i_walk_dim];
            end else if (r_reduce[i_walk_dim]) begin
                n_addr = r_addr + r_stride[i_walk_dim];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_coord[i]  <= '0;
                r_iter[i]   <= EXT_W'(1);
                r_reduce[i] <= 1'b1;
                r_stride[i] <= '0;
                r_wrap[i]   <= '0;
            end
        end else begin
            r_addr <= n_addr;
            for (int i = 0; i < MAX_DIMS; i++) begin
                // loads beyond capacity match no entry
                if (i_cmd.load_write && int'(r_ld_dim) == i) begin
                    r_iter[i]   <= r_ld_iter;
                    r_reduce[i] <= (r_ld_iter == r_ld_src);
                    r_stride[i] <= r_ld_stride;
                    r_wrap[i]   <= wrap;
                end
                if (i_cmd.start) begin
                    r_coord[i] <= '0;
                end else if (i_cmd.walk && i_walk_dim == IDX_W'(i)) begin
                    r_coord[i] <= adv ? next_coord[EXT_W-1:0] : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ld_dim    <= i_dim_index;
            r_ld_iter   <= i_iteration_extent;
            r_ld_src    <= i_source_extent;
            r_ld_stride <= $unsigned(i_stride);
        end
        if (i_cmd.load_mul) begin
            r_prod_lo  <= prod_lo;
            r_prod_hi  <= prod_hi;
            r_src_zero <= (r_ld_src == '0);
        end
        if (i_cmd.emit) begin
            r_out_address <= r_addr;
            r_out_done    <= i_cmd.emit_done;
        end
    end

    assign o_address  = r_out_address;
    assign o_done_res = r_out_done;

endmodule

[design/sndag_ctrl.sv]
`timescale 1ns / 1ps

module sndag_ctrl import sndag_pkg::*; #(
    parameter int  MAX_DIMS = DEF_MAX_DIMS,
    localparam int IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int CNT_W    = $clog2(MAX_DIMS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_op,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_dp_cmd               o_cmd,
    output logic [IDX_W-1:0]      o_walk_dim,
    input  t_dp_status            i_status
);

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_k, n_k;
    logic                  r_done, n_done;
    logic                  r_out_valid, n_out_valid;
    logic [DIMS_CFG_W-1:0] r_dims;
    logic                  r_reverse;

    logic                  in_accept;
    logic                  slot_free;
    logic                  last;
    logic [CNT_W-1:0]      active;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign slot_free  = !r_out_valid || i_out_ready;

    assign active = (int'(r_dims) > MAX_DIMS) ? CNT_W'(MAX_DIMS) : CNT_W'(r_dims);
    assign last   = (CNT_W'(r_k) + CNT_W'(1)) == active;
    assign o_walk_dim = r_reverse ? r_k
                                  : IDX_W'(active - CNT_W'(1) - CNT_W'(r_k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims    <= DIMS_CFG_W'(1);
            r_reverse <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DIMS_IN_USE: r_dims    <= i_cfg_data[DIMS_CFG_W-1:0];
                CFG_REVERSE:     r_reverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (t_op'(i_op))
                        OP_LOAD:  n_state = ST_LOAD_MUL;
                        OP_START: n_state = ST_EMIT;
                        OP_STEP:  n_state = (active == '0) ? ST_EMIT : ST_WALK;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_MUL:   n_state = ST_LOAD_WRITE;
            ST_LOAD_WRITE: n_state = ST_IDLE;
            ST_WALK: begin
                if (i_status.advance || last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        o_cmd       = '0;
        n_k         = r_k;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    unique case (t_op'(i_op))
                        OP_LOAD: o_cmd.capture = 1'b1;
                        OP_START: begin
                            o_cmd.start = 1'b1;
                            n_done      = 1'b0;
                        end
                        OP_STEP: begin
                            n_k    = '0;
                            n_done = (active == '0);
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD_MUL:   o_cmd.load_mul   = 1'b1;
            ST_LOAD_WRITE: o_cmd.load_write = 1'b1;
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.advance) begin
                    n_done = 1'b0;
                end else if (last) begin
                    n_done = 1'b1;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_done = r_done;
                    n_out_valid     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (CNT_W'(r_k) < active))
        else $error("walk counter beyond active dimensions");

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while pending");

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_op == OP_START) |=> (r_state == ST_EMIT && !r_done))
        else $error("start request did not go to emit with done clear");

    a_advance_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && i_status.advance) |=> (r_state == ST_EMIT && !r_done))
        else $error("walk continued after a dimension advanced");

endmodule

[design/strided_nd_address_generator.sv]
// Strided N-dimensional address generator. Requests on i_in carry an op: load (0) writes
// one dimension's iteration extent, source extent and signed stride; start (1) sets the
// address and clears all coordinates; step (2) advances the coordinates like an odometer
// and moves the address, adding the stride only where iteration and source extents match,
// and subtracting stride*(source_extent-1) for every dimension that wraps. Start and step
// each return one result (address, done_res); load and op 3 return none. Registers on
// i_cfg: index 0 dims_in_use (values above MAX_DIMS act as MAX_DIMS), index 1
// reverse_order. A load passes through capture, multiply and table write; a start goes
// straight to emit; a step walks the dimensions that it visits (the wrapped ones plus
// the one that advances, at most dims_in_use clamped to MAX_DIMS), then emits. The walk
// visits one dimension per cycle, updating the address register. The result sits in
// an output register, so the next request is taken while a result waits; a new result
// is only written once the previous one has been taken.
`timescale 1ns / 1ps

module strided_nd_address_generator import sndag_pkg::*; #(
    parameter int MAX_DIMS = DEF_MAX_DIMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sndag_in_if.sink    i_in,
    sndag_out_if.source o_out,
    sndag_cfg_if.sink   i_cfg
);

    localparam int IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [IDX_W-1:0] walk_dim;

    // Sequencer: op decode, dimension walk order, result handshake, config registers
    sndag_ctrl #(
        .MAX_DIMS (MAX_DIMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cmd       (cmd),
        .o_walk_dim  (walk_dim),
        .i_status    (status)
    );

    // Dimension tables, coordinates, address register, wrap-offset multiplier
    sndag_dp #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_walk_dim         (walk_dim),
        .o_status           (status),
        .i_dim_index        (i_in.dim_index),
        .i_iteration_extent (i_in.iteration_extent),
        .i_source_extent    (i_in.source_extent),
        .i_stride           (i_in.stride),
        .i_start_address    (i_in.start_address),
        .o_address          (o_out.address),
        .o_done_res         (o_out.done_res)
    );

endmodule

[bench/strided_nd_address_generator_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench: every accepted request runs through a local odometer model,
// and every accepted result is compared against the oldest prediction.
module strided_nd_address_generator_tb;
    import sndag_pkg::*;

    localparam int MAX_DIMS      = DEF_MAX_DIMS;
    localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES = 16;    // settle time, longer than the worst step or load
    localparam int WALK_PHASES   = 10;
    localparam int WALK_ITEMS    = 140;
    localparam int REPORT_LIMIT  = 10;

    // op code 3 is not in t_op; the block must drop it silently
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // dims_in_use per random phase: both extremes, plus 0 and out-of-range values
    localparam int PHASE_DIMS [WALK_PHASES] = '{8, 1, 3, 0, 15, 2, 5, 8, 4, 7};
    // idle patterns, indexed by phase % 4: none, sender only, receiver only, both
    localparam int SEND_IDLE  [4] = '{0, 49, 0, 30};
    localparam int RECV_STALL [4] = '{0, 0, 49, 30};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DIM_W-1:0]  dim_index;
        logic [EXT_W-1:0]  iteration_extent;
        logic [EXT_W-1:0]  source_extent;
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] start_address;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              done_res;
    } t_addr_result;

    // ------------------------------------------------------------------
    // Clock, reset, channels
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sndag_in_if  in_if ();
    sndag_out_if out_if ();
    sndag_cfg_if cfg_if ();

    // Bench-side copies of everything we drive; known from time zero.
    t_request              in_req    = '0;
    logic                  in_valid  = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    assign in_if.valid            = in_valid;
    assign in_if.op               = in_req.op;
    assign in_if.dim_index        = in_req.dim_index;
    assign in_if.iteration_extent = in_req.iteration_extent;
    assign in_if.source_extent    = in_req.source_extent;
    assign in_if.stride           = in_req.stride;
    assign in_if.start_address    = in_req.start_address;
    assign out_if.ready           = out_ready;
    assign cfg_if.valid           = cfg_valid;
    assign cfg_if.index           = cfg_index;
    assign cfg_if.data            = cfg_data;

    strided_nd_address_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_request     pending_requests [$];  // filled by the sequence, drained by the driver
    t_addr_result expected_addrs [$];    // predicted results, oldest first
    logic         in_fire        = 1'b0; // request taken at the last rising edge
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_reqs      = 0;    // bumped by the sequence to ask for a long hold
    int unsigned  hold_seen      = 0;
    int unsigned  hold_left      = 0;
    int unsigned  error_count    = 0;

    // ------------------------------------------------------------------
    // Odometer model: address register, coordinates, per-dimension tables
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]     addr_now                 = '0;
    logic [EXT_W-1:0]      coord_now    [MAX_DIMS]  = '{default: '0};
    logic [EXT_W-1:0]      iter_ext_tbl [MAX_DIMS]  = '{default: 1};
    logic [EXT_W-1:0]      src_ext_tbl  [MAX_DIMS]  = '{default: 1};
    logic [ADDR_W-1:0]     stride_tbl   [MAX_DIMS]  = '{default: '0};
    logic [DIMS_CFG_W-1:0] dims_cfg                 = 1;
    logic                  rev_cfg                  = 1'b0;

    // Returns 1 when the request yields a result, placed in res.
    function automatic bit predict_address(input t_request r, output t_addr_result res);
        int unsigned       n_active;
        int unsigned       d;
        bit                moved;
        logic [EXT_W:0]    next_coord;
        logic [ADDR_W-1:0] span;
        res = '0;
        predict_address = 1'b0;
        case (r.op)
            OP_LOAD: begin
                if (r.dim_index < MAX_DIMS) begin
                    iter_ext_tbl[r.dim_index] = r.iteration_extent;
                    src_ext_tbl[r.dim_index]  = r.source_extent;
                    stride_tbl[r.dim_index]   = r.stride;
                end
            end
            OP_START: begin
                addr_now = r.start_address;
                for (int i = 0; i < MAX_DIMS; i++) coord_now[i] = '0;
                res.address = addr_now;
                predict_address = 1'b1;
            end
            OP_STEP: begin
                // dims_in_use above capacity is clamped; 0 means nothing moves
                n_active = (int'(dims_cfg) > MAX_DIMS) ? MAX_DIMS : int'(dims_cfg);
                moved = 1'b0;
                for (int unsigned k = 0; k < n_active && !moved; k++) begin
                    d = rev_cfg ? k : n_active - 1 - k;
                    next_coord = {1'b0, coord_now[d]} + (EXT_W+1)'(1);
                    // zero extent compares like one: always wraps
                    if (next_coord < {1'b0, iter_ext_tbl[d]}) begin
                        coord_now[d] = next_coord[EXT_W-1:0];
                        // stride only counts where the axis is not reduced
                        if (iter_ext_tbl[d] == src_ext_tbl[d])
                            addr_now = addr_now + stride_tbl[d];
                        moved = 1'b1;
                    end else begin
                        coord_now[d] = '0;
                        // zero source extent gives span of all ones: net +stride
                        span = {{(ADDR_W-EXT_W){1'b0}}, src_ext_tbl[d]} - ADDR_W'(1);
                        addr_now = addr_now - stride_tbl[d] * span;
                    end
                end
                res.address  = addr_now;
                res.done_res = !moved;
                predict_address = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("mismatch #%0d: %s", error_count, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the next pending request at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_req   = pending_requests.pop_front();
                in_valid = 1'b1;
            end else begin
                in_valid = 1'b0;
            end
        end
    end

    // Result-side ready: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else begin
            out_ready = i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: all handshakes sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_addr_result want;
        t_addr_result got;
        in_fire = in_valid && in_if.ready;
        if (i_rst_n) begin
            // check first: a result leaving now belongs to an older request
            if (out_if.valid && out_ready) begin
                got.address  = out_if.address;
                got.done_res = out_if.done_res;
                if (expected_addrs.size() == 0) begin
                    note_error($sformatf("result with nothing pending: address %h done %0b",
                                         got.address, got.done_res));
                end else begin
                    want = expected_addrs.pop_front();
                    if (got.address !== want.address || got.done_res !== want.done_res)
                        note_error($sformatf(
                            "expected address %h done %0b, got address %h done %0b",
                            want.address, want.done_res, got.address, got.done_res));
                end
            end
            if (in_fire && predict_address(in_req, want)) expected_addrs.push_back(want);
            if (cfg_valid && cfg_if.ready) begin
                case (cfg_index)
                    CFG_DIMS_IN_USE: dims_cfg = cfg_data;
                    CFG_REVERSE:     rev_cfg  = cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // unused fields carry random bits so the block cannot lean on them
    function automatic t_request random_request();
        t_request r;
        r.op               = OP_W'($urandom);
        r.dim_index        = DIM_W'($urandom);
        r.iteration_extent = $urandom;
        r.source_extent    = $urandom;
        r.stride           = rand64();
        r.start_address    = rand64();
        return r;
    endfunction

    function automatic logic [EXT_W-1:0] pick_extent(input int unsigned small_max);
        int unsigned r = $urandom_range(99);
        if (r < 80) return EXT_W'($urandom_range(small_max, 1));
        if (r < 88) return '0;
        if (r < 94) return '1;
        return $urandom;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_stride();
        int unsigned r = $urandom_range(99);
        longint      v;
        if (r < 40) begin
            v = longint'($urandom_range(16)) - 8;
            return v;
        end
        if (r < 80) return rand64();
        case ($urandom_range(3))
            0:       return {1'b0, {(ADDR_W-1){1'b1}}};
            1:       return {1'b1, {(ADDR_W-1){1'b0}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic push_load(input logic [DIM_W-1:0] dim, input logic [EXT_W-1:0] it_ext,
                             input logic [EXT_W-1:0] src_ext, input logic [ADDR_W-1:0] stride);
        t_request r = random_request();
        r.op               = OP_LOAD;
        r.dim_index        = dim;
        r.iteration_extent = it_ext;
        r.source_extent    = src_ext;
        r.stride           = stride;
        pending_requests.push_back(r);
    endtask

    task automatic push_start(input logic [ADDR_W-1:0] addr);
        t_request r = random_request();
        r.op            = OP_START;
        r.start_address = addr;
        pending_requests.push_back(r);
    endtask

    task automatic push_step();
        t_request r = random_request();
        r.op = OP_STEP;
        pending_requests.push_back(r);
    endtask

    task automatic push_unused();
        t_request r = random_request();
        r.op = OP_UNUSED;
        pending_requests.push_back(r);
    endtask

    // Config writes only happen once the block is idle (see wait_drained).
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Sender stays quiet until every predicted result is back, then lets a
    // load or dropped request still in flight finish.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || in_valid || expected_addrs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One walk: fill all dimension tables with small extents (so wraps and done
    // show up often), start, then mostly steps with reloads, restarts and noise.
    task automatic queue_walk(input int unsigned n_dims, input int unsigned n_items);
        int unsigned      n_eff     = (n_dims > MAX_DIMS) ? MAX_DIMS : n_dims;
        int unsigned      small_max = (n_eff > 4) ? 2 : 4;
        int unsigned      sent      = MAX_DIMS + 1;
        int unsigned      r;
        logic [EXT_W-1:0] ext;
        for (int unsigned d = 0; d < MAX_DIMS; d++) begin
            ext = EXT_W'($urandom_range(small_max, 1));
            push_load(DIM_W'(d), ext, ($urandom_range(3) != 0) ? ext : pick_extent(small_max),
                      pick_stride());
        end
        push_start(rand64());
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r >= 94) begin
                push_unused();
            end else begin
                if (r < 78) push_step();
                else if (r < 86) push_load(DIM_W'($urandom_range(MAX_DIMS - 1)),
                                           pick_extent(small_max), pick_extent(small_max),
                                           pick_stride());
                else push_start(rand64());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset tables, one dimension: a step wraps at once and reports done.
        push_step();
        push_start('1);
        push_unused();
        push_step();
        // plain 3-long axis, then a reduced axis (extents differ, no stride add)
        push_load(0, 3, 3, 1);
        push_start('0);
        repeat (3) push_step();
        push_load(0, 2, 5, 7);
        push_step();
        push_step();
        wait_drained();

        // All eight dimensions with field extremes: zero iteration extent with zero
        // source extent, full-range extents, most negative and most positive strides.
        write_reg(CFG_DIMS_IN_USE, 4'd8);
        write_reg(CFG_REVERSE, 4'd0);
        push_load(7, '0, '0, {1'b0, {(ADDR_W-1){1'b1}}});
        push_load(6, '1, '1, {1'b1, {(ADDR_W-1){1'b0}}});
        push_load(5, 2, 2, '1);
        push_start(64'h0123_4567_89ab_cdef);
        push_step();
        push_step();
        // shrink dim 6 under its coordinate: it must wrap on the next visit
        push_load(6, 1, 1, 5);
        push_step();
        push_step();
        wait_drained();

        // no active dimensions: address holds, done every step
        write_reg(CFG_DIMS_IN_USE, 4'd0);
        write_reg(CFG_REVERSE, 4'd1);
        push_step();
        push_start('0);
        push_step();
        wait_drained();

        // dims_in_use beyond capacity, reverse scan
        write_reg(CFG_DIMS_IN_USE, 4'd15);
        push_step();
        push_step();

        for (int p = 0; p < WALK_PHASES; p++) begin
            wait_drained();
            send_idle_pct  = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            write_reg(CFG_DIMS_IN_USE, CFG_DATA_W'(PHASE_DIMS[p]));
            write_reg(CFG_REVERSE, CFG_DATA_W'((p >> 1) & 1));
            // first walk: hold results off long enough that the input backs up
            if (p == 0) hold_reqs++;
            queue_walk(PHASE_DIMS[p], WALK_ITEMS);
        end
        wait_drained();

        if (error_count == 0) begin
            $display("[strided_nd_address_generator] OK");
        end else begin
            $display("[strided_nd_address_generator] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[strided_nd_address_generator] ERROR");
        $finish;
    end

endmodule
